FILE: rtl/assert_macros.svh
// Concurrent assertion macros for the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lfa_pkg.sv
// Shared constants, types and helpers for the lowest-free-id allocator
`timescale 1ns / 1ps

package lfa_pkg;

    localparam int UNIVERSE = 1024;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int NWORDS   = (UNIVERSE + WORD_W - 1) / WORD_W;
    localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int VAL_W    = 10;
    localparam int CMD_W    = 2;
    localparam int REM_BITS = UNIVERSE % WORD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic {
        SRC_REQ  = 1'b0,
        SRC_FREE = 1'b1
    } rd_src_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_en;
        logic    wr_alloc;
        logic    set_bit;
        logic    load_out;
    } dp_ctl_t;

    typedef struct packed {
        logic in_range;
    } dp_sts_t;

    function automatic logic [WORD_W-1:0] valid_mask(input logic [AW-1:0] w);
        logic [WORD_W-1:0] m;
        m = '1;
        if ((REM_BITS != 0) && (int'(w) == NWORDS - 1))
        begin
            m = (WORD_W'(1) << REM_BITS) - WORD_W'(1);
        end
        return m;
    endfunction

endpackage

FILE: rtl/lfa_req_if.sv
// Request channel: command word with handshake
`timescale 1ns / 1ps

interface lfa_req_if
    import lfa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: rtl/lfa_rsp_if.sv
// Response channel: lowest free value and status with handshake
`timescale 1ns / 1ps

interface lfa_rsp_if
    import lfa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] lowest_free;
    logic             status;

    modport source (output valid, output lowest_free, output status, input ready);
    modport sink   (input valid, input lowest_free, input status, output ready);
endinterface

FILE: rtl/lfa_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module lfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lfa_dp.sv
// Datapath: occupancy RAM, full-word summary, bit update and lowest-free search
`timescale 1ns / 1ps

module lfa_dp
    import lfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_ctl_t          ctl,
    output dp_sts_t          sts,
    input  logic [VAL_W-1:0] req_value,
    output logic [VAL_W-1:0] lowest_free,
    output logic             status
);

    logic [VAL_W-1:0]  val_reg;
    logic [NWORDS-1:0] summary_reg;
    logic [NWORDS-1:0] valid_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              rd_valid_reg;
    logic              any_free_reg;
    logic [VAL_W-1:0]  lowest_free_reg;
    logic              status_reg;

    logic [AW-1:0]     free_word;
    logic              any_free;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] vmask;
    logic [WORD_W-1:0] bit_onehot;
    logic [WORD_W-1:0] mod_word;
    logic [WORD_W-1:0] free_bits;
    logic [BIT_W-1:0]  free_pos;
    logic [WORD_W-1:0] alloc_word;
    logic [WORD_W-1:0] wr_data;
    logic              wr_en;

    always_comb
    begin
        free_word = '0;
        any_free  = 1'b0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (!summary_reg[i])
            begin
                free_word = AW'(i);
                any_free  = 1'b1;
            end
        end
    end

    assign rd_addr = (ctl.rd_src == SRC_FREE) ? free_word : AW'(req_value >> BIT_W);

    lfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_occ_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rd_addr_reg),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_word   = rd_valid_reg ? rd_data : '0;
    assign vmask      = valid_mask(rd_addr_reg);
    assign bit_onehot = WORD_W'(1) << val_reg[BIT_W-1:0];
    assign mod_word   = ctl.set_bit ? (cur_word | bit_onehot) : (cur_word & ~bit_onehot);
    assign free_bits  = ~cur_word & vmask;

    always_comb
    begin
        free_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                free_pos = BIT_W'(i);
            end
        end
    end

    assign alloc_word = cur_word | (WORD_W'(1) << free_pos);
    assign wr_data    = ctl.wr_alloc ? alloc_word : mod_word;
    assign wr_en      = ctl.wr_en && (!ctl.wr_alloc || any_free_reg);

    assign sts.in_range = int'(val_reg) < UNIVERSE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summary_reg <= '0;
            valid_reg   <= '0;
        end
        else if (wr_en)
        begin
            summary_reg[rd_addr_reg] <= ((wr_data & vmask) == vmask);
            valid_reg[rd_addr_reg]   <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            val_reg <= req_value;
        end
        if (ctl.rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
            any_free_reg <= any_free;
        end
        if (ctl.load_out)
        begin
            lowest_free_reg <= any_free_reg ? VAL_W'({rd_addr_reg, free_pos}) : '0;
            status_reg      <= !any_free_reg;
        end
    end

    assign lowest_free = lowest_free_reg;
    assign status      = status_reg;

endmodule

FILE: rtl/lfa_ctrl.sv
// Controller: sequences read, update, search and response for each command word
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lfa_ctrl
    import lfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  dp_sts_t          sts,
    output dp_ctl_t          ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FIND,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load  = 1'b1;
                    ctl.rd_en = 1'b1;
                    cmd_next  = cmd_t'(req_cmd);
                    if (req_cmd == CMD_ALLOC)
                    begin
                        ctl.rd_src = SRC_FREE;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        ctl.rd_src = SRC_REQ;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                ctl.wr_en   = ((cmd_reg == CMD_MARK) || (cmd_reg == CMD_RELEASE))
                              && sts.in_range;
                ctl.set_bit = (cmd_reg == CMD_MARK);
                state_next  = S_FIND;
            end
            S_FIND:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = SRC_FREE;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.load_out   = 1'b1;
                    ctl.wr_en      = (cmd_reg == CMD_ALLOC);
                    ctl.wr_alloc   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_MARK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
    `ASSERT_NEXT(a_alloc_to_scan, req_valid && req_ready && (req_cmd == CMD_ALLOC), state_reg == S_SCAN, "allocate skipped search")
    `ASSERT_IMPLY(a_no_write_idle, ctl.wr_en, state_reg != S_IDLE, "write while idle")

endmodule

FILE: rtl/lowest_free_id_allocator_core.sv
// Allocate reads the lowest non-full word, then scans it; mark, release and
// unknown commands step through read, update, search read and scan. A new
// command word is taken only in idle, once the previous one has left the scan.
// A waiting result does not block the next accept.
// Reset: async active low; the 16-entry valid bits and full summary clear at once.
`timescale 1ns / 1ps

module lowest_free_id_allocator_core
    import lfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lfa_req_if.sink   req,
    lfa_rsp_if.source rsp
);

    dp_ctl_t ctl;
    dp_sts_t sts;

    lfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lfa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .req_value   (req.value),
        .lowest_free (rsp.lowest_free),
        .status      (rsp.status)
    );

endmodule

FILE: tb/lfa_checker.sv
// Allocator checker: tracks the used set, predicts each result word and compares it
`timescale 1ns / 1ps

module lfa_checker
    import lfa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lfa_req_if   req,
    lfa_rsp_if   rsp,
    output int   errors,
    output int   outstanding
);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] lowest_free;
        logic             status;
    } lowest_answer_t;

    logic [UNIVERSE-1:0] taken_ids;
    lowest_answer_t      answers_due[$];
    lowest_answer_t      oldest;
    int                  words_seen;

    initial
    begin
        errors = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch on result word %0d: %s", $realtime, words_seen, what);
        errors++;
    endtask

    function automatic lowest_answer_t apply_command(input logic [CMD_W-1:0] op,
                                                     input logic [VAL_W-1:0] id);
        lowest_answer_t answer;
        int             lowest;
        lowest = -1;
        if ((op == CMD_MARK || op == CMD_RELEASE) && int'(id) < UNIVERSE)
        begin
            taken_ids[id] = (op == CMD_MARK);
        end
        for (int i = UNIVERSE - 1; i >= 0; i--)
        begin
            if (!taken_ids[i])
            begin
                lowest = i;
            end
        end
        if (op == CMD_ALLOC && lowest >= 0)
        begin
            taken_ids[lowest] = 1'b1;
        end
        if (lowest >= 0)
        begin
            answer.lowest_free = VAL_W'(lowest);
            answer.status      = STATUS_OK;
        end
        else
        begin
            answer.lowest_free = '0;
            answer.status      = STATUS_FULL;
        end
        return answer;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_ids = '0;
            answers_due.delete();
            words_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                answers_due.push_back(apply_command(req.cmd, req.value));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word lowest_free=%0d status=%0b",
                                              rsp.lowest_free, rsp.status));
                end
                else
                begin
                    oldest = answers_due.pop_front();
                    if (rsp.lowest_free !== oldest.lowest_free)
                    begin
                        report_mismatch($sformatf("lowest_free %0d, want %0d",
                                                  rsp.lowest_free, oldest.lowest_free));
                    end
                    if (rsp.status !== oldest.status)
                    begin
                        report_mismatch($sformatf("status %0b, want %0b",
                                                  rsp.status, oldest.status));
                    end
                end
                words_seen++;
            end
            outstanding <= answers_due.size();
        end
    end

endmodule

FILE: tb/tb_lowest_free_id_allocator_core.sv
// Testbench top: drives command words into the allocator and gives the verdict
`timescale 1ns / 1ps

module tb_lowest_free_id_allocator_core
    import lfa_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_UNDEFINED = 2'd3;
    localparam int               CYCLE_LIMIT   = 400000;

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   cycles;
    int   gap_pct;
    logic steady;

    lfa_req_if req ();
    lfa_rsp_if rsp ();

    lowest_free_id_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    lfa_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] id);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= op;
        req.value <= id;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
    endtask

    function automatic logic [VAL_W-1:0] pick_id();
        int offs;
        case ($urandom_range(3))
            0:
            begin
                offs = $urandom_range(1) ? $urandom_range(1) : WORD_W - 1 - $urandom_range(1);
                return VAL_W'($urandom_range(NWORDS - 1) * WORD_W + offs);
            end
            1: return VAL_W'($urandom_range(255));
            default: return VAL_W'($urandom_range(UNIVERSE - 1));
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd(input int mark_pct, input int alloc_pct,
                                                  input int release_pct);
        int r;
        r = $urandom_range(99);
        if (r < mark_pct)
        begin
            return CMD_MARK;
        end
        if (r < mark_pct + alloc_pct)
        begin
            return CMD_ALLOC;
        end
        if (r < mark_pct + alloc_pct + release_pct)
        begin
            return CMD_RELEASE;
        end
        return CMD_UNDEFINED;
    endfunction

    initial
    begin
        int bursty;
        bursty = 0;
        rsp.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!steady && $urandom_range(99) < 30)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            bursty = $urandom_range(9);
            repeat (bursty == 0 ? $urandom_range(120, 40) : $urandom_range(8, 1))
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        steady    = 1'b0;
        gap_pct   = 20;
        req.valid <= 1'b0;
        req.cmd   <= CMD_MARK;
        req.value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_ALLOC, 10'd0);
        send_word(CMD_MARK, 10'd0);
        send_word(CMD_RELEASE, 10'd5);
        send_word(CMD_MARK, 10'd1);
        send_word(CMD_MARK, 10'd1023);
        send_word(CMD_MARK, 10'd512);
        send_word(CMD_UNDEFINED, 10'd1023);
        send_word(CMD_UNDEFINED, 10'd0);
        send_word(CMD_RELEASE, 10'd0);
        send_word(CMD_ALLOC, 10'd0);
        send_word(CMD_ALLOC, 10'd1023);
        send_word(CMD_MARK, 10'd63);
        send_word(CMD_MARK, 10'd64);
        send_word(CMD_MARK, 10'd682);
        send_word(CMD_MARK, 10'd341);
        send_word(CMD_RELEASE, 10'd1023);
        send_word(CMD_RELEASE, 10'd1);
        send_word(CMD_ALLOC, 10'd682);
        send_word(CMD_RELEASE, 10'd682);
        send_word(CMD_RELEASE, 10'd341);
        send_word(CMD_RELEASE, 10'd2);
        send_word(CMD_RELEASE, 10'd0);

        for (int i = 0; i < 200; i++)
        begin
            if (i % 50 == 0)
            begin
                gap_pct = $urandom_range(1) ? 25 : 0;
            end
            send_word(pick_cmd(40, 30, 25), pick_id());
        end

        gap_pct = 10;
        for (int i = 0; i < UNIVERSE + 4; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_word(CMD_MARK, pick_id());
            end
            send_word(CMD_ALLOC, VAL_W'($urandom_range(UNIVERSE - 1)));
        end

        wait_drained();

        gap_pct = 20;
        for (int i = 0; i < 20; i++)
        begin
            send_word(CMD_RELEASE, pick_id());
            send_word(CMD_ALLOC, pick_id());
            send_word(CMD_ALLOC, pick_id());
            send_word(CMD_MARK, pick_id());
            send_word(CMD_UNDEFINED, pick_id());
        end

        steady  = 1'b1;
        gap_pct = 0;
        for (int i = 0; i < 120; i++)
        begin
            send_word(pick_cmd(25, 25, 45), pick_id());
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
